FILE: rtl/clc_pkg.sv
// shared types and constants for the combination lock controller
package clc_pkg;

    localparam int MAX_DIGITS = 16;
    localparam int DIGIT_BITS = 8;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    typedef enum logic [1:0] {
        CMD_DIGIT = 2'd0,
        CMD_RESET = 2'd1,
        CMD_LOAD  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_OPEN     = 2'd0,
        MODE_LOCKED   = 2'd1,
        MODE_ERROR    = 2'd2,
        MODE_LOCKDOWN = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_OPENED  = 3'd1,
        ACT_CLOSED  = 3'd2,
        ACT_ALARM   = 3'd3,
        ACT_CLEARED = 3'd4
    } action_t;

    typedef struct packed {
        logic                  wr_en;
        logic [IDX_W-1:0]      wr_addr;
        logic [DIGIT_BITS-1:0] wr_data;
    } store_wr_t;

endpackage

FILE: rtl/combination_lock_controller.sv
// top level of the combination lock controller with input and result registers
//
// keypad beats enter on key_valid / key_stall with fields command, digit
// and code_last; a beat is taken when key_valid is high and key_stall low.
// every keypad beat gives exactly one result beat on result_valid /
// result_stall with fields mode, action and overflow.
// a beat lands in the input register, the lock logic evaluates it in one
// pass against the code store and the mode registers, and the outcome is
// written to the result register, and one beat per cycle is sustained
// while result_stall is low.
// while result_stall is high the result holds and one more keypad beat
// waits in the input register; key_stall rises only when both are full.
// reset (rst_n low) empties both registers and returns the lock to open
// with no code loaded; the code store itself is not cleared.
module combination_lock_controller
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       key_valid,
    output logic       key_stall,
    input  logic [1:0] command,
    input  logic [7:0] digit,
    input  logic       code_last,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [1:0] mode,
    output logic [2:0] action,
    output logic       overflow
);

    logic                           in_valid_reg;
    logic                           in_valid_next;
    logic [1:0]                     cmd_reg;
    logic [clc_pkg::DIGIT_BITS-1:0] digit_reg;
    logic                           last_reg;
    logic                           res_valid_reg;
    logic                           res_valid_next;
    clc_pkg::mode_t                 mode_reg;
    clc_pkg::action_t               action_reg;
    logic                           overflow_reg;
    clc_pkg::mode_t                 core_mode;
    clc_pkg::action_t               core_action;
    logic                           core_overflow;
    logic                           advance;
    logic                           step;
    logic                           key_take;

    assign advance   = !res_valid_reg || !result_stall;
    assign step      = in_valid_reg && advance;
    assign key_stall = in_valid_reg && !advance;
    assign key_take  = key_valid && !key_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (key_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        res_valid_next = advance ? in_valid_reg : res_valid_reg;
    end

    clc_lock_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .command       (cmd_reg),
        .digit         (digit_reg),
        .code_last     (last_reg),
        .mode_next_out (core_mode),
        .action_out    (core_action),
        .overflow_out  (core_overflow)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_take)
        begin
            cmd_reg   <= command;
            digit_reg <= digit[clc_pkg::DIGIT_BITS-1:0];
            last_reg  <= code_last;
        end
        if (step)
        begin
            mode_reg     <= core_mode;
            action_reg   <= core_action;
            overflow_reg <= core_overflow;
        end
    end

    assign result_valid = res_valid_reg;
    assign mode         = mode_reg;
    assign action       = action_reg;
    assign overflow     = overflow_reg;

endmodule

FILE: rtl/clc_code_store.sv
// register file holding the digits of the active code
module clc_code_store
(
    input  logic                          clk,
    input  clc_pkg::store_wr_t            wr,
    input  logic [clc_pkg::IDX_W-1:0]     rd_addr,
    output logic [clc_pkg::DIGIT_BITS-1:0] rd_data
);

    logic [clc_pkg::DIGIT_BITS-1:0] store_reg [clc_pkg::MAX_DIGITS];

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            store_reg[wr.wr_addr] <= wr.wr_data;
        end
    end

    assign rd_data = store_reg[rd_addr];

endmodule

FILE: rtl/clc_lock_core.sv
// lock state registers and per-beat mode and action logic
module clc_lock_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [1:0]                     command,
    input  logic [clc_pkg::DIGIT_BITS-1:0] digit,
    input  logic                           code_last,
    output clc_pkg::mode_t                 mode_next_out,
    output clc_pkg::action_t               action_out,
    output logic                           overflow_out
);

    clc_pkg::mode_t                 mode_reg;
    clc_pkg::mode_t                 mode_next;
    logic [clc_pkg::CNT_W-1:0]      length_reg;
    logic [clc_pkg::CNT_W-1:0]      length_next;
    logic [clc_pkg::CNT_W-1:0]      pos_reg;
    logic [clc_pkg::CNT_W-1:0]      pos_next;
    logic [clc_pkg::CNT_W-1:0]      load_reg;
    logic [clc_pkg::CNT_W-1:0]      load_next;
    logic [clc_pkg::CNT_W-1:0]      pos_adv;
    logic [clc_pkg::CNT_W-1:0]      load_adv;
    logic [clc_pkg::DIGIT_BITS-1:0] rd_data;
    clc_pkg::store_wr_t             wr;
    clc_pkg::action_t               action;
    logic                           overflow;
    logic                           in_range;
    logic                           match;
    logic                           complete;
    logic                           has_room;

    clc_code_store u_store
    (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (pos_reg[clc_pkg::IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        in_range = (pos_reg < length_reg) &&
                   (pos_reg < clc_pkg::CNT_W'(clc_pkg::MAX_DIGITS));
        match    = in_range && (rd_data == digit);
        pos_adv  = in_range ? pos_reg + 1'b1 : pos_reg;
        complete = (pos_adv >= length_reg);
        has_room = (load_reg < clc_pkg::CNT_W'(clc_pkg::MAX_DIGITS));
        load_adv = has_room ? load_reg + 1'b1 : load_reg;

        mode_next   = mode_reg;
        length_next = length_reg;
        pos_next    = pos_reg;
        load_next   = load_reg;
        action      = clc_pkg::ACT_NONE;
        overflow    = 1'b0;
        wr.wr_en    = 1'b0;
        wr.wr_addr  = load_reg[clc_pkg::IDX_W-1:0];
        wr.wr_data  = digit;

        case (command)
            clc_pkg::CMD_LOAD:
            begin
                if (mode_reg == clc_pkg::MODE_OPEN)
                begin
                    wr.wr_en  = step && has_room;
                    overflow  = !has_room;
                    load_next = load_adv;
                    if (code_last)
                    begin
                        length_next = load_adv;
                        load_next   = '0;
                        pos_next    = '0;
                        mode_next   = clc_pkg::MODE_LOCKED;
                        action      = clc_pkg::ACT_CLOSED;
                    end
                end
            end
            clc_pkg::CMD_RESET:
            begin
                if (mode_reg == clc_pkg::MODE_LOCKED || mode_reg == clc_pkg::MODE_ERROR)
                begin
                    pos_next  = '0;
                    mode_next = clc_pkg::MODE_LOCKED;
                    action    = clc_pkg::ACT_CLEARED;
                end
                else if (mode_reg == clc_pkg::MODE_LOCKDOWN)
                begin
                    pos_next  = '0;
                    mode_next = clc_pkg::MODE_LOCKED;
                    action    = clc_pkg::ACT_CLOSED;
                end
            end
            clc_pkg::CMD_DIGIT:
            begin
                if (mode_reg == clc_pkg::MODE_LOCKED || mode_reg == clc_pkg::MODE_ERROR)
                begin
                    pos_next = pos_adv;
                    if (mode_reg == clc_pkg::MODE_LOCKED && match)
                    begin
                        if (complete)
                        begin
                            mode_next = clc_pkg::MODE_OPEN;
                            action    = clc_pkg::ACT_OPENED;
                        end
                    end
                    else if (complete)
                    begin
                        mode_next = clc_pkg::MODE_LOCKDOWN;
                        action    = clc_pkg::ACT_ALARM;
                    end
                    else
                    begin
                        mode_next = clc_pkg::MODE_ERROR;
                    end
                end
            end
            default:
            begin
                action = clc_pkg::ACT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= clc_pkg::MODE_OPEN;
            length_reg <= '0;
            pos_reg    <= '0;
            load_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            length_reg <= length_next;
            pos_reg    <= pos_next;
            load_reg   <= load_next;
        end
    end

    assign mode_next_out = mode_next;
    assign action_out    = action;
    assign overflow_out  = overflow;

endmodule
